// ===== hw/rtl/top_k_min_heap_keeper_top_assert.svh =====
// Assertion macros for the heap keeper checker
`ifndef TOP_K_MIN_HEAP_KEEPER_TOP_ASSERT_SVH
`define TOP_K_MIN_HEAP_KEEPER_TOP_ASSERT_SVH
`define TKH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap keeper check failed");
`define TKH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap keeper check failed");
`endif

// ===== hw/rtl/tkh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared constants and types for the top-k min-heap keeper.
// ----------------------------------------------------------------------------
package tkh_pkg;
    localparam int MAX_CAPACITY = 1024;
    localparam int SCORE_BITS   = 32;
    localparam int ADDR_BITS    = $clog2(MAX_CAPACITY);
    localparam int CNT_BITS     = ADDR_BITS + 1;
    localparam int VALUE_BITS   = 64;
    localparam int ENTRY_BITS   = VALUE_BITS + SCORE_BITS;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [SCORE_BITS-1:0] score;
    } t_entry;

    typedef struct packed {
        logic   operation;
        logic [63:0] candidate_value;
        logic [31:0] candidate_score;
        logic [9:0]  slot_index;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic [10:0] kept_count;
        logic [31:0] root_score;
        logic [63:0] read_value;
        logic [31:0] read_score;
    } t_out_word;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_mem_req;
endpackage

// ===== hw/rtl/tkh_stream_if.sv =====
// ----------------------------------------------------------------------------
// tkh_stream_if
// Valid/ready channel with a generic payload type.
// ----------------------------------------------------------------------------
interface tkh_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tkh_ram.sv =====
// ----------------------------------------------------------------------------
// tkh_ram
// One-write one-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tkh_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== hw/rtl/tkh_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkh_ctrl
// Sequencer: append, bottom-up build, sift-down and slot reads over the entry RAM.
// ----------------------------------------------------------------------------
module tkh_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [10:0]           i_capacity,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tkh_pkg::t_in_word     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tkh_pkg::t_out_word    o_out_data,
    output tkh_pkg::t_mem_req     o_req,
    input  tkh_pkg::t_entry       i_rdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDRD  = 4'd1;
    localparam logic [3:0] S_RDWT  = 4'd2;
    localparam logic [3:0] S_NODE  = 4'd3;
    localparam logic [3:0] S_LEFT  = 4'd4;
    localparam logic [3:0] S_RGHT  = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_SWAP  = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_RDL   = 4'd10;

    localparam int AB = tkh_pkg::ADDR_BITS;
    localparam int CB = tkh_pkg::CNT_BITS;

    logic [3:0]           r_state, n_state;
    tkh_pkg::t_cnt        r_count, n_count;
    tkh_pkg::t_cnt        r_size, n_size;
    tkh_pkg::t_cnt        r_node, n_node;
    tkh_pkg::t_cnt        r_child, n_child;
    tkh_pkg::t_cnt        r_bnode, n_bnode;
    logic                 r_build, n_build;
    logic                 r_acc, n_acc;
    logic                 r_isread, n_isread;
    tkh_pkg::t_entry      r_ne, n_ne;
    tkh_pkg::t_entry      r_le, n_le;
    tkh_pkg::t_entry      r_ce, n_ce;
    logic [31:0]          r_root, n_root;
    logic                 r_ovalid, n_ovalid;
    tkh_pkg::t_out_word   r_out, n_out;
    tkh_pkg::t_cnt        cap;
    tkh_pkg::t_cnt        last;
    tkh_pkg::t_cnt        c_left;

    always_comb begin
        if (i_capacity == '0) begin
            cap = CB'(1);
        end else if (i_capacity > CB'(tkh_pkg::MAX_CAPACITY)) begin
            cap = CB'(tkh_pkg::MAX_CAPACITY);
        end else begin
            cap = i_capacity;
        end
        last   = r_size - CB'(1);
        c_left = {r_node[CB-2:0], 1'b1};
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_size   = r_size;
        n_node   = r_node;
        n_child  = r_child;
        n_bnode  = r_bnode;
        n_build  = r_build;
        n_acc    = r_acc;
        n_isread = r_isread;
        n_ne     = r_ne;
        n_le     = r_le;
        n_ce     = r_ce;
        n_root   = r_root;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        o_req    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_acc    = 1'b0;
                    n_isread = 1'b0;
                    n_size   = cap;
                    if (i_in_data.operation == tkh_pkg::OP_READ) begin
                        n_isread   = 1'b1;
                        o_req.raddr = i_in_data.slot_index;
                        n_state    = S_RDWT;
                    end else if (r_count < cap) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = r_count[AB-1:0];
                        o_req.wdata = '{value: i_in_data.candidate_value,
                                        score: i_in_data.candidate_score};
                        if (r_count == '0) begin
                            n_root = i_in_data.candidate_score;
                        end
                        n_count = r_count + CB'(1);
                        n_acc   = 1'b1;
                        if (r_count + CB'(1) == cap) begin
                            n_build = 1'b1;
                            n_bnode = (cap - CB'(1)) >> 1;
                            n_node  = (cap - CB'(1)) >> 1;
                            n_state = S_RDRD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (r_root < i_in_data.candidate_score) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = '0;
                        o_req.wdata = '{value: i_in_data.candidate_value,
                                        score: i_in_data.candidate_score};
                        n_root  = i_in_data.candidate_score;
                        n_acc   = 1'b1;
                        n_build = 1'b0;
                        n_node  = '0;
                        n_state = S_RDRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RDRD: begin
                o_req.raddr = r_node[AB-1:0];
                n_child     = c_left;
                n_state     = S_NODE;
            end
            S_NODE: begin
                n_ne = i_rdata;
                if (r_child < r_size) begin
                    o_req.raddr = r_child[AB-1:0];
                    n_state     = S_LEFT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_LEFT: begin
                n_le = i_rdata;
                n_ce = i_rdata;
                if (r_child < last) begin
                    o_req.raddr = AB'(r_child + CB'(1));
                    n_state     = S_RGHT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_RGHT: begin
                if (r_le.score > i_rdata.score) begin
                    n_ce    = i_rdata;
                    n_child = r_child + CB'(1);
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_ne.score > r_ce.score) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_node[AB-1:0];
                    o_req.wdata = r_ce;
                    if (r_node == '0) begin
                        n_root = r_ce.score;
                    end
                    n_state = S_SWAP;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SWAP: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_child[AB-1:0];
                o_req.wdata = r_ne;
                n_node      = r_child;
                n_child     = {r_child[CB-2:0], 1'b1};
                if ({r_child[CB-2:0], 1'b1} < r_size && r_child < r_size) begin
                    o_req.raddr = AB'({r_child[CB-2:0], 1'b1});
                    n_state     = S_RDL;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_RDL: begin
                n_le = i_rdata;
                n_ce = i_rdata;
                if (r_child < last) begin
                    o_req.raddr = AB'(r_child + CB'(1));
                    n_state     = S_RGHT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_NEXT: begin
                if (r_build && r_bnode != '0) begin
                    n_bnode = r_bnode - CB'(1);
                    n_node  = r_bnode - CB'(1);
                    n_state = S_RDRD;
                end else begin
                    n_build = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_RDWT: begin
                // hold the read word, the RAM output moves on next cycle
                n_ce    = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_ovalid         = 1'b1;
                n_out.accepted   = r_acc;
                n_out.kept_count = r_count;
                n_out.root_score = r_root;
                n_out.read_value = r_isread ? r_ce.value : '0;
                n_out.read_score = r_isread ? r_ce.score : '0;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_build  <= 1'b0;
            r_ovalid <= 1'b0;
            r_root   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_build  <= n_build;
            r_ovalid <= n_ovalid;
            r_root   <= n_root;
        end
        r_size   <= n_size;
        r_node   <= n_node;
        r_child  <= n_child;
        r_bnode  <= n_bnode;
        r_acc    <= n_acc;
        r_isread <= n_isread;
        r_ne     <= n_ne;
        r_le     <= n_le;
        r_ce     <= n_ce;
        r_out    <= n_out;
    end
endmodule

// ===== hw/rtl/top_k_min_heap_keeper_top.sv =====
// ----------------------------------------------------------------------------
// top_k_min_heap_keeper_top
// Top-k keeper on a min-heap of value/score entries held in one RAM.
// Each sift level reads the node and its children and swaps the node with its
// smaller child when that child scores lower. Throughput: one word at a time,
// the next accepted in the cycle after the result is taken. The fill-time
// build walks (capacity+1)/2 sift-downs once.
// Reset clears the count and the handshake state; the RAM is not cleared.
// ----------------------------------------------------------------------------
module top_k_min_heap_keeper_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tkh_stream_if.sink       i_cfg,
    tkh_stream_if.sink       i_in,
    tkh_stream_if.source     o_out
);
    logic [10:0]        r_capacity;
    tkh_pkg::t_mem_req  req;
    tkh_pkg::t_entry    rdata;
    logic [tkh_pkg::ENTRY_BITS-1:0] rdata_raw;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 11'd1024;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    tkh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data),
        .o_req       (req),
        .i_rdata     (rdata)
    );

    tkh_ram #(
        .DEPTH (tkh_pkg::MAX_CAPACITY),
        .WIDTH (tkh_pkg::ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_raddr (req.raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata = rdata_raw;
endmodule

// ===== hw/rtl/tkh_checker.sv =====
// ----------------------------------------------------------------------------
// tkh_checker
// Port-level checks of the heap keeper, bound to the top level.
// ----------------------------------------------------------------------------
`include "top_k_min_heap_keeper_top_assert.svh"
module tkh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input tkh_pkg::t_out_word out_data
);
    `TKH_ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, out_valid, !in_ready)
    `TKH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_data))
    `TKH_ASSERT_IMPL(a_read_not_acc, i_clk, i_rst_n, out_valid, !(out_data.accepted && out_data.read_score != '0))
    `TKH_ASSERT_NEXT(a_no_instant_out, i_clk, i_rst_n, in_valid && in_ready, !out_valid)
endmodule

bind top_k_min_heap_keeper_top tkh_checker u_tkh_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_data  (o_out.data)
);
